/* src/assert_macros.svh */
// concurrent assertion helpers, clocked on clk and disabled during arst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, expr, msg)
`endif

`endif

/* src/jdcd_pkg.sv */
`default_nettype none

package jdcd_pkg;

	localparam int JD_W    = 32;
	localparam int YEAR_W  = 24;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;

	typedef logic signed [JD_W-1:0]   jd_t;
	typedef logic signed [YEAR_W-1:0] year_t;
	typedef logic [MONTH_W-1:0]       month_t;
	typedef logic [DAY_W-1:0]         day_t;

	// days counted from the start of a march-based year, plus bias
	typedef logic [9:0] doy_t;
	typedef logic [8:0] month_base_t;

	localparam int GREG_START  = 2299161;
	localparam int GREG_BASE   = 1867216;
	localparam int DAYS_400Y   = 146097;
	localparam int DAYS_100Y   = 36525;
	localparam int DAY_OFFSET  = 1524;
	localparam int YEAR_BIAS20 = 2442;
	localparam int DAYS_20Y    = 7305;
	localparam int MONTH_SCALE = 306001;
	localparam int MONTH_DIV   = 10000;
	localparam int YEAR_BASE   = 4715;

	localparam int DAYS_4Y       = DAYS_20Y / 5;
	localparam int DAYS_PER_YEAR = 365;
	localparam int YEARS_PER_SHIFT = 100;
	localparam int MONTHS_PER_YEAR = 12;

	// (20*tb - 2442) / 7305 == (4*(tb - TB_BIAS) + 3) / 1461
	localparam int TB_BIAS = (YEAR_BIAS20 / 5 + 4) / 4;

	// first day offset of each month slot: floor(30.6001 * te)
	localparam month_base_t DAY_BASE [16] = '{
		9'((MONTH_SCALE * 0) / MONTH_DIV),
		9'((MONTH_SCALE * 1) / MONTH_DIV),
		9'((MONTH_SCALE * 2) / MONTH_DIV),
		9'((MONTH_SCALE * 3) / MONTH_DIV),
		9'((MONTH_SCALE * 4) / MONTH_DIV),
		9'((MONTH_SCALE * 5) / MONTH_DIV),
		9'((MONTH_SCALE * 6) / MONTH_DIV),
		9'((MONTH_SCALE * 7) / MONTH_DIV),
		9'((MONTH_SCALE * 8) / MONTH_DIV),
		9'((MONTH_SCALE * 9) / MONTH_DIV),
		9'((MONTH_SCALE * 10) / MONTH_DIV),
		9'((MONTH_SCALE * 11) / MONTH_DIV),
		9'((MONTH_SCALE * 12) / MONTH_DIV),
		9'((MONTH_SCALE * 13) / MONTH_DIV),
		9'((MONTH_SCALE * 14) / MONTH_DIV),
		9'((MONTH_SCALE * 15) / MONTH_DIV)
	};

endpackage

`default_nettype wire

/* src/jdcd_recip_div.sv */
`default_nettype none

// unsigned floor(n / DIV) for any n below 2**N_W, by a rounded-up reciprocal
module jdcd_recip_div #(
	parameter int N_W = 32,
	parameter int DIV = 3,
	parameter int Q_W = 16
) (
	input  logic [N_W-1:0] n,
	output logic [Q_W-1:0] q
);

	localparam int L   = $clog2(DIV);
	localparam int K   = N_W + L;
	localparam int M_W = N_W + 2;
	localparam int P_W = N_W + M_W;
	localparam logic [63:0] M_FULL = ((64'd1 << K) + 64'(DIV) - 64'd1) / 64'(DIV);
	localparam logic [M_W-1:0] M = M_FULL[M_W-1:0];

	logic [P_W-1:0] prod;

	assign prod = P_W'(n) * P_W'(M);
	assign q    = prod[K +: Q_W];

endmodule

`default_nettype wire

/* src/julian_day_to_calendar_date_unit.sv */
// julian day number to calendar date converter
//
// input: a signed 32-bit day number is taken on day_number at any rising
// edge where start is high and busy is low. busy is always low, so a new
// transaction may be started in every cycle.
// output: done is high for exactly one cycle with year, month and day of
// that transaction; the receiver cannot hold results off and none is
// needed, since every transaction comes out in order.
// pipeline: from the accepting edge to done, a transaction passes an input
// register, seven arithmetic stages and a result register.
// throughput: one transaction per cycle; the pipeline length comes from the
// two rounds of reciprocal division, each with its multiply-back step, the
// gregorian correction and the month search, each kept to a short stage.
// reset: arst_n low clears every valid flag at once, so results in flight
// are dropped and done stays low; payload registers keep old data.
`default_nettype none
`include "assert_macros.svh"

module julian_day_to_calendar_date_unit import jdcd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	output logic   busy,
	input  jd_t    day_number,
	output logic   done,
	output year_t  year,
	output month_t month,
	output day_t   day
);

	logic accept;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic done_q;

	jd_t         jd_s1, jd_s2, jd_s3;
	logic        greg_s2, greg_s3, neg_s2;
	logic [15:0] q_s2;
	logic [14:0] q_s3;
	logic [17:0] r_s3;
	logic [31:0] ta_s3;
	logic [22:0] yoff_s3, yoff_s4, yoff_s5, yoff_s6, yoff_s7, yoff_s8;
	logic [31:0] v_s4, v_s5, v_s6;
	logic [21:0] a_s5;
	logic [23:0] tc_s6, tc_s7, tc_s8;
	doy_t        e_s7, e_s8;
	logic [3:0]  te_s8;
	year_t       year_q;
	month_t      month_q;
	day_t        day_q;

	// stage 1: range split and first division
	logic        greg_c, neg_c;
	logic [31:0] y_c, abs_c;
	logic [30:0] n_c;
	logic [14:0] qg_c;
	logic [15:0] qn_c, q_c;

	// stage 2: remainder and century shift
	logic [31:0] y2_c, r_full_c, ta_neg_c;
	logic [16:0] shift_c;
	logic [22:0] yoff_c;

	// stage 3: gregorian correction
	logic [19:0] x4_c;
	logic [1:0]  f_c;
	logic [16:0] alpha_c;
	logic [31:0] ta_g_c, ta_c, v_c;

	// stage 4..6: year count and day within year
	logic [21:0] a_c;
	logic [31:0] b_full_c, td_c, e_full_c;
	logic [12:0] bx_c;
	logic [1:0]  f2_c;
	logic [23:0] tc_c;

	// stage 7 and result
	logic [3:0] te_c, mm_raw_c, mm_c;
	doy_t       dd_c;
	year_t      yy_c;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_comb begin
		greg_c = jd_s1 >= 32'(GREG_START);
		neg_c  = jd_s1[JD_W-1];
		y_c    = unsigned'(jd_s1) - 32'(GREG_BASE);
		abs_c  = 32'd0 - unsigned'(jd_s1);
		// the most negative input has the same quotient as its neighbour
		n_c    = abs_c[31] ? '1 : abs_c[30:0];
		q_c    = greg_c ? {1'b0, qg_c} : qn_c;
	end

	jdcd_recip_div #(.N_W(31), .DIV(DAYS_400Y), .Q_W(15)) u_div_400y (
		.n (y_c[30:0]),
		.q (qg_c)
	);

	jdcd_recip_div #(.N_W(31), .DIV(DAYS_100Y), .Q_W(16)) u_div_100y (
		.n (n_c),
		.q (qn_c)
	);

	always_comb begin
		y2_c     = unsigned'(jd_s2) - 32'(GREG_BASE);
		r_full_c = y2_c - 32'(q_s2[14:0]) * 32'(DAYS_400Y);
		shift_c  = 17'(q_s2) + 17'd1;
		ta_neg_c = unsigned'(jd_s2) + 32'(shift_c) * 32'(DAYS_100Y);
		yoff_c   = neg_s2 ? 23'(shift_c) * 23'(YEARS_PER_SHIFT) : '0;
	end

	always_comb begin
		// alpha = floor((4*y - 1) / 146097) rebuilt from quotient and remainder
		x4_c    = {r_s3, 2'b00};
		f_c     = 2'(x4_c > 20'(DAYS_400Y)) + 2'(x4_c > 20'(2 * DAYS_400Y))
			+ 2'(x4_c > 20'(3 * DAYS_400Y));
		alpha_c = {q_s3, 2'b00} + 17'(f_c) - 17'(r_s3 == '0);
		ta_g_c  = unsigned'(jd_s3) + 32'd1 + 32'(alpha_c) - 32'(alpha_c[16:2]);
		ta_c    = greg_s3 ? ta_g_c : ta_s3;
		v_c     = ta_c + 32'(DAY_OFFSET - TB_BIAS);
	end

	jdcd_recip_div #(.N_W(32), .DIV(DAYS_4Y), .Q_W(22)) u_div_4y (
		.n (v_s4),
		.q (a_c)
	);

	always_comb begin
		b_full_c = v_s5 - 32'(a_s5) * 32'(DAYS_4Y);
		bx_c     = {b_full_c[10:0], 2'b00} + 13'd3;
		f2_c     = 2'(bx_c >= 13'(DAYS_4Y)) + 2'(bx_c >= 13'(2 * DAYS_4Y))
			+ 2'(bx_c >= 13'(3 * DAYS_4Y));
		tc_c     = {a_s5, 2'b00} + 24'(f2_c);
	end

	always_comb begin
		td_c     = 32'(tc_s6) * 32'(DAYS_PER_YEAR) + 32'(tc_s6[23:2]);
		e_full_c = v_s6 + 32'(TB_BIAS) - td_c;
	end

	// month slot: count of slot boundaries strictly below the day offset
	always_comb begin
		te_c = '0;
		for (int t = 1; t < 16; t++) begin
			te_c = te_c + 4'(e_s7 > 10'(DAY_BASE[t]));
		end
	end

	always_comb begin
		dd_c     = e_s8 - 10'(DAY_BASE[te_s8]);
		mm_raw_c = te_s8 - 4'd1;
		mm_c     = (mm_raw_c > 4'(MONTHS_PER_YEAR))
			? mm_raw_c - 4'(MONTHS_PER_YEAR) : mm_raw_c;
		yy_c     = year_t'(tc_s8 - 24'(YEAR_BASE) - 24'(mm_c > 4'd2) - 24'(yoff_s8));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			done_q <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			jd_s1 <= day_number;
		end
		jd_s2   <= jd_s1;
		greg_s2 <= greg_c;
		neg_s2  <= neg_c;
		q_s2    <= q_c;

		jd_s3   <= jd_s2;
		greg_s3 <= greg_s2;
		q_s3    <= q_s2[14:0];
		r_s3    <= r_full_c[17:0];
		ta_s3   <= neg_s2 ? ta_neg_c : unsigned'(jd_s2);
		yoff_s3 <= yoff_c;

		v_s4    <= v_c;
		yoff_s4 <= yoff_s3;

		a_s5    <= a_c;
		v_s5    <= v_s4;
		yoff_s5 <= yoff_s4;

		tc_s6   <= tc_c;
		v_s6    <= v_s5;
		yoff_s6 <= yoff_s5;

		e_s7    <= e_full_c[9:0];
		tc_s7   <= tc_s6;
		yoff_s7 <= yoff_s6;

		te_s8   <= te_c;
		e_s8    <= e_s7;
		tc_s8   <= tc_s7;
		yoff_s8 <= yoff_s7;

		year_q  <= yy_c;
		month_q <= mm_c;
		day_q   <= dd_c[DAY_W-1:0];
	end

	assign done  = done_q;
	assign year  = year_q;
	assign month = month_q;
	assign day   = day_q;

	`ASSERT_CLK(a_latency, accept |-> ##9 done,
		"accepted transaction did not complete in 9 cycles")
	`ASSERT_CLK(a_no_spurious, done |-> $past(accept, 9),
		"result without a matching transaction")
	`ASSERT_CLK(a_date_range,
		done |-> (month >= 4'd1 && month <= 4'(MONTHS_PER_YEAR) && day >= 5'd1),
		"month or day out of range")
	`ASSERT_NEVER(a_rem_400y, vld_s2 && greg_s2 && r_full_c >= 32'(DAYS_400Y),
		"400-year remainder out of range")
	`ASSERT_NEVER(a_rem_4y, vld_s5 && b_full_c >= 32'(DAYS_4Y),
		"4-year remainder out of range")

endmodule

`default_nettype wire
